// ===== hw/rtl/sidta_pkg.sv =====
package sidta_pkg;

  localparam int MAX_CHARS  = 12;
  localparam int VAL_W      = 32;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int CNT_W      = $clog2(MAX_CHARS + 1);
  localparam int SHIFT_W    = $clog2(VAL_W);
  localparam int DIGIDX_W   = $clog2(NUM_DIGITS + 1);
  localparam int CAP_W      = 4;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(12);
  localparam logic [CAP_W-1:0] CAP_MIN   = CAP_W'(2);

  // word address of each register
  localparam logic ADDR_CAPACITY = 1'b0;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

endpackage

// ===== hw/rtl/sidta_dabble.sv =====
module sidta_dabble (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [sidta_pkg::VAL_W-1:0]      mag,
  output logic                             done,
  output logic [sidta_pkg::BCD_W-1:0]      bcd
);

  logic [sidta_pkg::VAL_W-1:0]   bin;
  logic [sidta_pkg::SHIFT_W-1:0] cnt;
  logic                          busy;
  logic [sidta_pkg::BCD_W-1:0]   adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < sidta_pkg::NUM_DIGITS; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= sidta_pkg::SHIFT_W'(sidta_pkg::VAL_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bin <= mag;
      bcd <= '0;
    end else if (busy) begin
      bcd <= {adj[sidta_pkg::BCD_W-2:0], bin[sidta_pkg::VAL_W-1]};
      bin <= {bin[sidta_pkg::VAL_W-2:0], 1'b0};
    end
  end

endmodule

// ===== hw/rtl/signed_int_to_decimal_ascii.sv =====
// channel   | dir | tdata (low bit up)                    | tlast
// s_axis    | in  | [31:0] value                          | -
// m_axis    | out | [7:0] character, [11:8] char_count    | is_last
// apb       | in  | 0x0 capacity (4 bits)                 | -
//
// a value is accepted, converted by a 32-step bit-serial binary to bcd
// shift, then sized to the text, then sent one character per cycle while
// m_tready is high; only one value is in flight at a time.
// rst is synchronous and returns capacity to 12.
// a stalled m_tready holds the current character; the next value is taken
// once the last character has been loaded into the output register.
module signed_int_to_decimal_ascii (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [31:0]                    s_tdata,   // [31:0] value
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [15:0]                    m_tdata,   // [7:0] character, [11:8] char_count
  output logic                           m_tlast,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sidta_pkg::ADDR_W-1:0]   paddr,
  input  logic [sidta_pkg::DATA_W-1:0]   pwdata,
  output logic [sidta_pkg::DATA_W-1:0]   prdata,
  output logic                           pready
);

  typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_EMIT} state_t;

  state_t                            state;
  logic [sidta_pkg::CAP_W-1:0]       capacity;
  logic                              neg;
  logic [sidta_pkg::DIGIDX_W-1:0]    dleft;
  logic                              sign_pend;
  logic [sidta_pkg::CNT_W-1:0]       total;
  logic [7:0]                        out_char;
  logic [sidta_pkg::CNT_W-1:0]       out_count;

  logic                              start;
  logic [sidta_pkg::VAL_W-1:0]       mag;
  logic                              conv_done;
  logic [sidta_pkg::BCD_W-1:0]       bcd;
  logic [3:0]                        digit [sidta_pkg::NUM_DIGITS];
  logic [sidta_pkg::DIGIDX_W-1:0]    sig;
  logic [sidta_pkg::CAP_W-1:0]       cap_eff;
  logic [sidta_pkg::CNT_W-1:0]       room;
  logic [sidta_pkg::CNT_W-1:0]       keep;
  logic [sidta_pkg::DIGIDX_W-1:0]    didx;
  logic                              load;

  assign pready   = 1'b1;
  assign prdata   = sidta_pkg::DATA_W'(capacity);
  assign s_tready = (state == ST_IDLE);
  assign start    = s_tvalid && s_tready;
  assign mag      = s_tdata[31] ? (~s_tdata + 1'b1) : s_tdata;
  assign m_tdata  = {4'b0, out_count, out_char};

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= sidta_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && paddr[2] == sidta_pkg::ADDR_CAPACITY) begin
      capacity <= pwdata[sidta_pkg::CAP_W-1:0];
    end
  end

  sidta_dabble u_dabble (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mag   (mag),
    .done  (conv_done),
    .bcd   (bcd)
  );

  // significant digit count, zero counts as one digit
  always_comb begin
    sig = sidta_pkg::DIGIDX_W'(1);
    for (int i = 0; i < sidta_pkg::NUM_DIGITS; i++) begin
      digit[i] = bcd[4*i +: 4];
      if (bcd[4*i +: 4] != 4'd0) begin
        sig = sidta_pkg::DIGIDX_W'(i + 1);
      end
    end
  end

  always_comb begin
    if (capacity < sidta_pkg::CAP_MIN) begin
      cap_eff = sidta_pkg::CAP_MIN;
    end else if (capacity > sidta_pkg::CAP_W'(sidta_pkg::MAX_CHARS)) begin
      cap_eff = sidta_pkg::CAP_W'(sidta_pkg::MAX_CHARS);
    end else begin
      cap_eff = capacity;
    end
    room = sidta_pkg::CNT_W'(cap_eff) - sidta_pkg::CNT_W'(1) - sidta_pkg::CNT_W'(neg);
    keep = (sidta_pkg::CNT_W'(sig) < room) ? sidta_pkg::CNT_W'(sig) : room;
  end

  assign didx = dleft - 1'b1;
  assign load = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      m_tvalid  <= 1'b0;
      m_tlast   <= 1'b0;
      neg       <= 1'b0;
      sign_pend <= 1'b0;
      dleft     <= '0;
      total     <= '0;
    end else begin
      // while emitting, every accepted character is replaced at once
      if (m_tvalid && m_tready && state != ST_EMIT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            neg   <= s_tdata[31];
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (conv_done) begin
            sign_pend <= neg;
            dleft     <= sidta_pkg::DIGIDX_W'(keep);
            total     <= keep + sidta_pkg::CNT_W'(1) + sidta_pkg::CNT_W'(neg);
            state     <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (load) begin
            m_tvalid  <= 1'b1;
            out_count <= total;
            priority if (sign_pend) begin
              out_char  <= sidta_pkg::CHAR_MINUS;
              m_tlast   <= 1'b0;
              sign_pend <= 1'b0;
            end else if (dleft != '0) begin
              out_char <= sidta_pkg::CHAR_ZERO + {4'b0, digit[didx]};
              m_tlast  <= 1'b0;
              dleft    <= didx;
            end else begin
              out_char <= sidta_pkg::CHAR_NUL;
              m_tlast  <= 1'b1;
              state    <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/sidta_checker.sv =====
module sidta_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tlast
);

  // a stalled request stays up
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("m_tvalid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  // terminator and last mark go together
  a_last_nul: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[7:0] == sidta_pkg::CHAR_NUL)))
    else $error("tlast does not match terminator");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[11:8] >= 4'd2) && (m_tdata[11:8] <= 4'(sidta_pkg::MAX_CHARS)))
    else $error("char_count out of range");

  // one value at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while converting");

endmodule

bind signed_int_to_decimal_ascii sidta_checker u_sidta_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ===== bench/sidta_text_checker.sv =====
module sidta_text_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  input  logic                         s_tready,
  input  logic [31:0]                  s_tdata,   // [31:0] value
  input  logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic [15:0]                  m_tdata,   // [7:0] character, [11:8] char_count
  input  logic                         m_tlast,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [sidta_pkg::ADDR_W-1:0] paddr,
  input  logic [sidta_pkg::DATA_W-1:0] pwdata,
  input  logic [sidta_pkg::DATA_W-1:0] prdata,
  output int                           fail_count,
  output int                           pending
);

  localparam logic [sidta_pkg::ADDR_W-1:0] CAPACITY_ADDR =
    sidta_pkg::ADDR_W'(4 * sidta_pkg::ADDR_CAPACITY);

  typedef struct packed {
    logic [7:0]                  character;
    logic                        is_last;
    logic [sidta_pkg::CNT_W-1:0] char_count;
  } text_char_t;

  text_char_t                  text_q[$];
  logic [sidta_pkg::CAP_W-1:0] capacity_reg;

  // expected characters of one conversion, appended to text_q
  function automatic void predict_text(input logic [31:0] value,
                                       input logic [sidta_pkg::CAP_W-1:0] cap_field);
    logic        neg;
    logic [31:0] mag;
    logic [3:0]  dig [sidta_pkg::NUM_DIGITS];
    int          ndig;
    int          cap;
    int          room;
    int          keep;
    int          total;
    neg  = value[31];
    mag  = neg ? (32'd0 - value) : value;
    cap  = cap_field;
    ndig = 0;
    if (cap < sidta_pkg::CAP_MIN) cap = sidta_pkg::CAP_MIN;
    if (cap > sidta_pkg::MAX_CHARS) cap = sidta_pkg::MAX_CHARS;
    if (mag == 0) begin
      text_q.push_back('{sidta_pkg::CHAR_ZERO, 1'b0, sidta_pkg::CNT_W'(2)});
      text_q.push_back('{sidta_pkg::CHAR_NUL, 1'b1, sidta_pkg::CNT_W'(2)});
      return;
    end
    while (mag != 0 && ndig < sidta_pkg::NUM_DIGITS) begin
      dig[ndig] = 4'(mag % 10);
      mag = mag / 10;
      ndig++;
    end
    room  = cap - 1 - int'(neg);
    keep  = (ndig < room) ? ndig : room;
    total = keep + 1 + int'(neg);
    if (neg) text_q.push_back('{sidta_pkg::CHAR_MINUS, 1'b0, sidta_pkg::CNT_W'(total)});
    // high digits fall away when the buffer is short
    for (int i = keep; i > 0; i--) begin
      text_q.push_back('{sidta_pkg::CHAR_ZERO + 8'(dig[i-1]), 1'b0,
                         sidta_pkg::CNT_W'(total)});
    end
    text_q.push_back('{sidta_pkg::CHAR_NUL, 1'b1, sidta_pkg::CNT_W'(total)});
  endfunction

  always @(posedge clk) begin
    text_char_t exp_char;
    if (rst) begin
      text_q.delete();
      capacity_reg = sidta_pkg::CAP_RESET;
    end else begin
      if (psel && penable && pready && paddr == CAPACITY_ADDR) begin
        if (pwrite) begin
          capacity_reg = pwdata[sidta_pkg::CAP_W-1:0];
        end else if (prdata !== sidta_pkg::DATA_W'(capacity_reg)) begin
          $display("%0t: capacity read: expected %0d, actual %0d", $time, capacity_reg, prdata);
          fail_count++;
        end
      end
      // drain before predicting so a new request never matches an older output
      if (m_tvalid && m_tready) begin
        if (text_q.size() == 0) begin
          $display("%0t: unexpected character: expected none, actual 0x%02h last %0b count %0d",
                   $time, m_tdata[7:0], m_tlast, m_tdata[11:8]);
          fail_count++;
        end else begin
          exp_char = text_q.pop_front();
          if (m_tdata[7:0] !== exp_char.character) begin
            $display("%0t: character: expected 0x%02h, actual 0x%02h", $time,
                     exp_char.character, m_tdata[7:0]);
            fail_count++;
          end
          if (m_tlast !== exp_char.is_last) begin
            $display("%0t: is_last: expected %0b, actual %0b", $time, exp_char.is_last, m_tlast);
            fail_count++;
          end
          if (m_tdata[11:8] !== exp_char.char_count) begin
            $display("%0t: char_count: expected %0d, actual %0d", $time,
                     exp_char.char_count, m_tdata[11:8]);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) predict_text(s_tdata, capacity_reg);
    end
    pending = text_q.size();
  end

endmodule

// ===== bench/signed_int_to_decimal_ascii_tb.sv =====
module signed_int_to_decimal_ascii_tb;

  localparam logic [sidta_pkg::ADDR_W-1:0] CAPACITY_ADDR =
    sidta_pkg::ADDR_W'(4 * sidta_pkg::ADDR_CAPACITY);

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         s_tvalid;
  logic                         s_tready;
  logic [31:0]                  s_tdata;   // [31:0] value
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [15:0]                  m_tdata;   // [7:0] character, [11:8] char_count
  logic                         m_tlast;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [sidta_pkg::ADDR_W-1:0] paddr;
  logic [sidta_pkg::DATA_W-1:0] pwdata;
  logic [sidta_pkg::DATA_W-1:0] prdata;
  logic                         pready;
  logic                         steady = 1'b0;
  int                           fail_count;
  int                           pending;

  signed_int_to_decimal_ascii u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sidta_text_checker u_chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= !rst && (steady || $urandom_range(0, 99) >= 33);
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  task automatic send_value(input logic [31:0] value);
    while (!steady && $urandom_range(0, 99) < 33) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    // settle on the low phase, then take the request at the next edge
    forever begin
      @(negedge clk);
      if (s_tready) break;
    end
    @(posedge clk);
  endtask

  task automatic apb_access(input logic write, input logic [3:0] cap_value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= CAPACITY_ADDR;
    pwdata  <= sidta_pkg::DATA_W'(cap_value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [3:0] cap_value);
    drain();
    apb_access(1'b1, cap_value);
    apb_access(1'b0, 4'd0);
  endtask

  function automatic logic [31:0] random_value();
    int          k;
    logic [31:0] mag;
    case ($urandom_range(0, 4))
      0: return 32'($urandom_range(0, 20)) - 32'd10;
      1: begin
        k   = $urandom_range(1, 9);
        mag = $urandom_range(10 ** (k - 1), 10 ** k - 1);
        return $urandom_range(0, 1) ? 32'd0 - mag : mag;
      end
      2: return $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                     : 32'h7fff_ffff - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [3:0] cap_value;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset capacity of 12
    apb_access(1'b0, 4'd0);
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hffff_ffff);
    send_value(32'h7fff_ffff);
    send_value(32'h8000_0000);
    send_value(32'd9);
    send_value(32'd10);
    send_value(-32'd10);
    send_value(32'd99999);
    send_value(32'd1000000000);
    send_value(-32'd999999999);
    send_value(32'haaaa_5555);

    // narrowest buffer: negative leaves no digit room
    set_capacity(4'd2);
    send_value(-32'd5);
    send_value(32'd5);
    send_value(32'd0);
    send_value(32'h8000_0000);

    // below the minimum, clamped up
    set_capacity(4'd0);
    send_value(32'hffff_ffff);
    send_value(32'd42);
    set_capacity(4'd1);
    send_value(32'd7);

    // above the maximum, clamped down
    set_capacity(4'd15);
    send_value(32'h8000_0000);
    send_value(32'h7fff_ffff);
    set_capacity(4'd13);
    send_value(-32'd1000000000);

    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0: cap_value = 4'd12;
        1: cap_value = 4'd2;
        2: cap_value = 4'd3;
        default: cap_value = $urandom_range(0, 15);
      endcase
      set_capacity(cap_value);
      steady = (phase == 4);
      for (int n = 0; n < 12; n++) send_value(random_value());
      steady = 1'b0;
    end

    drain();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
